FILE: sv/wdr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wdr_pkg
// Shared types, codes and the control program of the weighted draw block.
// ----------------------------------------------------------------------------
package wdr_pkg;

    localparam int WEIGHT_W   = 24;
    localparam int FRACTION_W = 32;
    localparam int PERSON_W   = 10;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_FIRST = 2'd1,
        CMD_NEXT  = 2'd2,
        CMD_CLEAR = 2'd3
    } command_t;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_NEW     = 2'd1,
        ST_SEEN    = 2'd2,
        ST_REFUSED = 2'd3
    } status_t;

    typedef struct packed {
        command_t                command;
        logic [WEIGHT_W-1:0]     weight;
        logic [FRACTION_W-1:0]   random_fraction;
    } draw_cmd_t;

    typedef struct packed {
        logic [PERSON_W-1:0] person;
        status_t             status;
    } draw_res_t;

    // Datapath action selected by one control word
    typedef enum logic [3:0] {
        ACT_NOP     = 4'd0,
        ACT_LATCH   = 4'd1,
        ACT_MUL_LO  = 4'd2,
        ACT_MUL_HI  = 4'd3,
        ACT_TARGET  = 4'd4,
        ACT_ISSUE   = 4'd5,
        ACT_SEARCH  = 4'd6,
        ACT_FLAG_RD = 4'd7,
        ACT_MARK    = 4'd8,
        ACT_LOAD    = 4'd9,
        ACT_CLEAR   = 4'd10,
        ACT_REFUSE  = 4'd11
    } act_t;

    // Jump condition of one control word
    typedef enum logic [2:0] {
        COND_NEXT     = 3'd0,
        COND_ALWAYS   = 3'd1,
        COND_IS_LOAD  = 3'd2,
        COND_IS_CLEAR = 3'd3,
        COND_EMPTY    = 3'd4,
        COND_LO_EQ_HI = 3'd5,
        COND_MORE     = 3'd6
    } cond_t;

    localparam int STEP_W = 4;
    typedef logic [STEP_W-1:0] step_t;

    localparam step_t STEP_FETCH     = 4'd0;
    localparam step_t STEP_DEC_LOAD  = 4'd1;
    localparam step_t STEP_DEC_CLEAR = 4'd2;
    localparam step_t STEP_DEC_EMPTY = 4'd3;
    localparam step_t STEP_MUL_LO    = 4'd4;
    localparam step_t STEP_MUL_HI    = 4'd5;
    localparam step_t STEP_TARGET    = 4'd6;
    localparam step_t STEP_ISSUE     = 4'd7;
    localparam step_t STEP_SEARCH    = 4'd8;
    localparam step_t STEP_FLAG_RD   = 4'd9;
    localparam step_t STEP_MARK      = 4'd10;
    localparam step_t STEP_LOAD      = 4'd11;
    localparam step_t STEP_CLEAR     = 4'd12;
    localparam step_t STEP_REFUSE    = 4'd13;

    typedef struct packed {
        act_t  act;
        logic  emit;
        cond_t cond;
        step_t target;
    } ucode_word_t;

    typedef struct packed {
        act_t act;
        logic go;
        logic emit;
    } dp_ctrl_t;

    typedef struct packed {
        logic is_load;
        logic is_clear;
        logic empty;
        logic lo_eq_hi;
        logic more;
        logic out_free;
    } dp_status_t;

    // Control program: one word per step
    function automatic ucode_word_t ucode_rom(input step_t step);
        ucode_word_t w;
        w = '{act: ACT_NOP, emit: 1'b0, cond: COND_ALWAYS, target: STEP_FETCH};
        case (step)
            STEP_FETCH:     w = '{ACT_LATCH,   1'b0, COND_NEXT,     STEP_FETCH};
            STEP_DEC_LOAD:  w = '{ACT_NOP,     1'b0, COND_IS_LOAD,  STEP_LOAD};
            STEP_DEC_CLEAR: w = '{ACT_NOP,     1'b0, COND_IS_CLEAR, STEP_CLEAR};
            STEP_DEC_EMPTY: w = '{ACT_NOP,     1'b0, COND_EMPTY,    STEP_REFUSE};
            STEP_MUL_LO:    w = '{ACT_MUL_LO,  1'b0, COND_NEXT,     STEP_FETCH};
            STEP_MUL_HI:    w = '{ACT_MUL_HI,  1'b0, COND_NEXT,     STEP_FETCH};
            STEP_TARGET:    w = '{ACT_TARGET,  1'b0, COND_NEXT,     STEP_FETCH};
            STEP_ISSUE:     w = '{ACT_ISSUE,   1'b0, COND_LO_EQ_HI, STEP_FLAG_RD};
            STEP_SEARCH:    w = '{ACT_SEARCH,  1'b0, COND_MORE,     STEP_SEARCH};
            STEP_FLAG_RD:   w = '{ACT_FLAG_RD, 1'b0, COND_NEXT,     STEP_FETCH};
            STEP_MARK:      w = '{ACT_MARK,    1'b1, COND_ALWAYS,   STEP_FETCH};
            STEP_LOAD:      w = '{ACT_LOAD,    1'b1, COND_ALWAYS,   STEP_FETCH};
            STEP_CLEAR:     w = '{ACT_CLEAR,   1'b1, COND_ALWAYS,   STEP_FETCH};
            STEP_REFUSE:    w = '{ACT_REFUSE,  1'b1, COND_ALWAYS,   STEP_FETCH};
            default:        w = '{ACT_NOP,     1'b0, COND_ALWAYS,   STEP_FETCH};
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

FILE: sv/wdr_seq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wdr_seq
// Step counter and control store; holds on input or output backpressure.
// ----------------------------------------------------------------------------
module wdr_seq (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cmd_valid,
    output logic                   cmd_stall,
    input  wire wdr_pkg::dp_status_t stat,
    output wdr_pkg::dp_ctrl_t      ctrl
);

    wdr_pkg::step_t       step_reg;
    wdr_pkg::step_t       step_next;
    wdr_pkg::ucode_word_t cw;
    logic                 hold;
    logic                 taken;

    always_comb
    begin
        cw = wdr_pkg::ucode_rom(step_reg);
    end

    // hold the fetch step until an item arrives, an emit step until the
    // output register is free
    always_comb
    begin
        hold = ((cw.act == wdr_pkg::ACT_LATCH) && !cmd_valid) ||
               (cw.emit && !stat.out_free);
    end

    always_comb
    begin
        case (cw.cond)
            wdr_pkg::COND_NEXT:     taken = 1'b0;
            wdr_pkg::COND_ALWAYS:   taken = 1'b1;
            wdr_pkg::COND_IS_LOAD:  taken = stat.is_load;
            wdr_pkg::COND_IS_CLEAR: taken = stat.is_clear;
            wdr_pkg::COND_EMPTY:    taken = stat.empty;
            wdr_pkg::COND_LO_EQ_HI: taken = stat.lo_eq_hi;
            wdr_pkg::COND_MORE:     taken = stat.more;
            default:                taken = 1'b0;
        endcase
    end

    always_comb
    begin
        if (hold)
        begin
            step_next = step_reg;
        end
        else if (taken)
        begin
            step_next = cw.target;
        end
        else
        begin
            step_next = step_reg + wdr_pkg::step_t'(1);
        end
    end

    always_comb
    begin
        ctrl.act  = cw.act;
        ctrl.go   = !hold;
        ctrl.emit = cw.emit;
        cmd_stall = (cw.act != wdr_pkg::ACT_LATCH);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= wdr_pkg::STEP_FETCH;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule
`default_nettype wire

FILE: sv/wdr_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wdr_dpath
// Cumulative table, mark memory, shared multiplier, search window, result reg.
// ----------------------------------------------------------------------------
module wdr_dpath #(
    parameter int MAX_PEOPLE  = 1024,
    parameter int WEIGHT_BITS = 24
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire wdr_pkg::dp_ctrl_t ctrl,
    output wdr_pkg::dp_status_t    stat,
    input  wire wdr_pkg::draw_cmd_t cmd_item,
    output logic                   res_valid,
    input  wire logic              res_stall,
    output wdr_pkg::draw_res_t     res_item
);

    localparam int IDX_W   = (MAX_PEOPLE > 1) ? $clog2(MAX_PEOPLE) : 1;
    localparam int CNT_W   = $clog2(MAX_PEOPLE + 1);
    localparam int WB_W    = (WEIGHT_BITS < wdr_pkg::WEIGHT_W) ? WEIGHT_BITS
                                                               : wdr_pkg::WEIGHT_W;
    localparam int TOTAL_W = WB_W + IDX_W;
    localparam int FRAC_W  = wdr_pkg::FRACTION_W;
    localparam int PROD_W  = 2 * FRAC_W;
    localparam int PX_W    = (IDX_W > wdr_pkg::PERSON_W) ? IDX_W : wdr_pkg::PERSON_W;

    // persistent state
    logic [CNT_W-1:0]    count_reg,  count_next;
    logic [TOTAL_W-1:0]  total_reg,  total_next;
    logic                res_valid_reg, res_valid_next;

    // per-item working registers
    wdr_pkg::command_t   cmd_reg,    cmd_next;
    logic [WB_W-1:0]     weight_reg, weight_next;
    logic [FRAC_W-1:0]   frac_reg,   frac_next;
    logic [PROD_W-1:0]   prod_reg,   prod_next;
    logic [FRAC_W-1:0]   acc_reg,    acc_next;
    logic [TOTAL_W-1:0]  target_reg, target_next;
    logic [IDX_W-1:0]    lo_reg,     lo_next;
    logic [IDX_W-1:0]    hi_reg,     hi_next;
    logic [IDX_W-1:0]    mid_reg,    mid_next;
    wdr_pkg::draw_res_t  res_reg,    res_next;

    // memories
    logic [TOTAL_W-1:0]  tbl_mem [MAX_PEOPLE];
    logic                flag_mem [MAX_PEOPLE];
    logic [TOTAL_W-1:0]  tbl_rdata_reg;
    logic                flag_rdata_reg;

    logic                tbl_we;
    logic [IDX_W-1:0]    tbl_waddr;
    logic [TOTAL_W-1:0]  tbl_wdata;
    logic [IDX_W-1:0]    tbl_raddr;
    logic                flag_we;
    logic [IDX_W-1:0]    flag_waddr;
    logic                flag_wdata;
    logic                flag_re;

    logic [PROD_W-1:0]   total_wide;
    logic [FRAC_W-1:0]   mul_a;
    logic [PROD_W-1:0]   mul_p;
    logic [IDX_W-1:0]    lo_s;
    logic [IDX_W-1:0]    hi_s;
    logic                more;
    logic                full;
    logic                out_free;

    function automatic logic [IDX_W-1:0] midpoint(input logic [IDX_W-1:0] a,
                                                   input logic [IDX_W-1:0] b);
        return a + ((b - a) >> 1);
    endfunction

    function automatic logic [wdr_pkg::PERSON_W-1:0] to_person(
        input logic [IDX_W-1:0] idx);
        logic [PX_W-1:0] wide;
        wide = PX_W'(idx);
        return wide[wdr_pkg::PERSON_W-1:0];
    endfunction

    // one 32x32 multiplier, shared by the low and high halves of the total
    always_comb
    begin
        total_wide = PROD_W'(total_reg);
        mul_a      = (ctrl.act == wdr_pkg::ACT_MUL_HI) ? total_wide[PROD_W-1:FRAC_W]
                                                       : total_wide[FRAC_W-1:0];
        mul_p      = PROD_W'(mul_a) * PROD_W'(frac_reg);
    end

    // one search iteration: compare the probe read last cycle, narrow the window
    always_comb
    begin
        if (target_reg < tbl_rdata_reg)
        begin
            lo_s = lo_reg;
            hi_s = mid_reg;
        end
        else
        begin
            lo_s = mid_reg + IDX_W'(1);
            hi_s = hi_reg;
        end
        more      = (hi_s > lo_s);
        tbl_raddr = (ctrl.act == wdr_pkg::ACT_SEARCH) ? midpoint(lo_s, hi_s)
                                                      : midpoint(lo_reg, hi_reg);
    end

    always_comb
    begin
        full     = (count_reg == CNT_W'(MAX_PEOPLE));
        out_free = !res_valid_reg || !res_stall;
    end

    always_comb
    begin
        count_next     = count_reg;
        total_next     = total_reg;
        cmd_next       = cmd_reg;
        weight_next    = weight_reg;
        frac_next      = frac_reg;
        prod_next      = prod_reg;
        acc_next       = acc_reg;
        target_next    = target_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && res_stall;
        tbl_we         = 1'b0;
        tbl_waddr      = count_reg[IDX_W-1:0];
        tbl_wdata      = total_reg + TOTAL_W'(weight_reg);
        flag_we        = 1'b0;
        flag_waddr     = lo_reg;
        flag_wdata     = 1'b0;
        flag_re        = 1'b0;

        if (ctrl.go)
        begin
            case (ctrl.act)
                wdr_pkg::ACT_LATCH:
                begin
                    cmd_next    = cmd_item.command;
                    weight_next = cmd_item.weight[WB_W-1:0];
                    frac_next   = cmd_item.random_fraction;
                end
                wdr_pkg::ACT_MUL_LO:
                begin
                    prod_next = mul_p;
                end
                wdr_pkg::ACT_MUL_HI:
                begin
                    prod_next = mul_p;
                    acc_next  = prod_reg[PROD_W-1:FRAC_W];
                end
                wdr_pkg::ACT_TARGET:
                begin
                    target_next = TOTAL_W'(prod_reg + PROD_W'(acc_reg));
                    lo_next     = '0;
                    hi_next     = IDX_W'(count_reg - CNT_W'(1));
                end
                wdr_pkg::ACT_ISSUE:
                begin
                    mid_next = tbl_raddr;
                end
                wdr_pkg::ACT_SEARCH:
                begin
                    lo_next  = lo_s;
                    hi_next  = hi_s;
                    mid_next = tbl_raddr;
                end
                wdr_pkg::ACT_FLAG_RD:
                begin
                    flag_re = 1'b1;
                end
                wdr_pkg::ACT_MARK:
                begin
                    flag_we    = 1'b1;
                    flag_waddr = lo_reg;
                    flag_wdata = 1'b1;
                    res_next   = '{person: to_person(lo_reg),
                                   status: ((cmd_reg == wdr_pkg::CMD_NEXT) && flag_rdata_reg)
                                           ? wdr_pkg::ST_SEEN : wdr_pkg::ST_NEW};
                end
                wdr_pkg::ACT_LOAD:
                begin
                    if (full)
                    begin
                        res_next = '{person: '0, status: wdr_pkg::ST_REFUSED};
                    end
                    else
                    begin
                        // a freshly loaded entry starts unmarked
                        total_next = tbl_wdata;
                        tbl_we     = 1'b1;
                        flag_we    = 1'b1;
                        flag_waddr = count_reg[IDX_W-1:0];
                        flag_wdata = 1'b0;
                        count_next = count_reg + CNT_W'(1);
                        res_next   = '{person: to_person(count_reg[IDX_W-1:0]),
                                       status: wdr_pkg::ST_DONE};
                    end
                end
                wdr_pkg::ACT_CLEAR:
                begin
                    count_next = '0;
                    total_next = '0;
                    res_next   = '{person: '0, status: wdr_pkg::ST_DONE};
                end
                wdr_pkg::ACT_REFUSE:
                begin
                    res_next = '{person: '0, status: wdr_pkg::ST_REFUSED};
                end
                default:
                begin
                end
            endcase
            if (ctrl.emit)
            begin
                res_valid_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        stat.is_load  = (cmd_reg == wdr_pkg::CMD_LOAD);
        stat.is_clear = (cmd_reg == wdr_pkg::CMD_CLEAR);
        stat.empty    = (count_reg == '0);
        stat.lo_eq_hi = (lo_reg == hi_reg);
        stat.more     = more;
        stat.out_free = out_free;
        res_valid     = res_valid_reg;
        res_item      = res_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            total_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            total_reg     <= total_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        weight_reg <= weight_next;
        frac_reg   <= frac_next;
        prod_reg   <= prod_next;
        acc_reg    <= acc_next;
        target_reg <= target_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        mid_reg    <= mid_next;
        res_reg    <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            tbl_mem[tbl_waddr] <= tbl_wdata;
        end
        tbl_rdata_reg <= tbl_mem[tbl_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (flag_we)
        begin
            flag_mem[flag_waddr] <= flag_wdata;
        end
        if (flag_re)
        begin
            flag_rdata_reg <= flag_mem[lo_reg];
        end
    end

`ifndef SYNTHESIS
    a_total_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (total_reg == '0))
        else $error("weight total nonzero with an empty table");

    a_search_window: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.act == wdr_pkg::ACT_SEARCH) |->
            ((lo_reg < hi_reg) && (CNT_W'(hi_reg) < count_reg)))
        else $error("search window empty or beyond loaded entries");

    a_mark_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.go && (ctrl.act == wdr_pkg::ACT_MARK)) |-> (CNT_W'(lo_reg) < count_reg))
        else $error("draw selected an entry that was never loaded");

    a_load_count: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.go && (ctrl.act == wdr_pkg::ACT_LOAD) && !full) |=>
            (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("accepted load did not advance the entry count");

    a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(ctrl.go && ctrl.emit))
        else $error("result raised without an emitting step");
`endif

endmodule
`default_nettype wire

FILE: sv/weighted_draw_without_repeat_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// weighted_draw_without_repeat_top
// Load: fetch, load decode, load (table write unless full, then the result).
// Clear: fetch, two decode steps, clear. Draw on an empty table: fetch, three
// decode steps, refuse. Draw: fetch, three decodes, low and high multiply,
// target, issue, up to clog2(MAX_PEOPLE) search iterations (10 at 1024
// entries), flag read, mark; each iteration is one read of the single table
// port, compared in the next cycle. One item in flight at a time. Reset:
// count and total zero, sequencer at fetch, output empty; no clearing pass,
// as marks are cleared entry by entry when loaded.
//
// Inverse-CDF weighted draw. Loads append a weight and store the running
// sum in the cumulative table. A draw scales the total by the random
// fraction (two passes through one 32x32 multiplier: low half, then high
// half plus the carried upper word), then binary-searches the table for the
// first entry above the target and sets that person's mark.
//
// Control is a small microprogram (wdr_pkg::ucode_rom) stepped by wdr_seq;
// wdr_dpath holds the table, the mark memory and all working registers.
// The result register decouples the output: a new item is taken while a
// result still waits to be taken, and an emitting step holds until the
// register frees up.
//
module weighted_draw_without_repeat_top #(
    parameter int MAX_PEOPLE  = 1024,
    parameter int WEIGHT_BITS = 24
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cmd_valid,
    output logic                   cmd_stall,
    input  wire wdr_pkg::draw_cmd_t cmd_item,
    output logic                   res_valid,
    input  wire logic              res_stall,
    output wdr_pkg::draw_res_t     res_item
);

    // control from the sequencer, conditions back from the datapath
    wdr_pkg::dp_ctrl_t   ctrl;
    wdr_pkg::dp_status_t stat;

    wdr_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    wdr_dpath #(
        .MAX_PEOPLE  (MAX_PEOPLE),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .stat      (stat),
        .cmd_item  (cmd_item),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item)
    );

endmodule
`default_nettype wire

FILE: dv/testbench.sv
`default_nettype none
// ----------------------------------------------------------------------------
// testbench
// Drives load, draw and clear commands into the weighted draw block. Every
// accepted command is run through a cycle-free copy of the cumulative table
// and its marks, and the predicted person and status are compared with the
// results as they come out. Both sides of the handshake idle at random.
// ----------------------------------------------------------------------------
module testbench;

    localparam int MAX_PEOPLE   = 1024;
    localparam int WEIGHT_BITS  = 24;
    localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
    localparam int DRAIN_CYCLES = 40;
    localparam int ITEMS_TOTAL  = 1800;
    localparam int PHASE_ITEMS  = 350;   // items per idling phase before the last

    localparam int WEIGHT_W   = wdr_pkg::WEIGHT_W;
    localparam int FRACTION_W = wdr_pkg::FRACTION_W;
    localparam int PERSON_W   = wdr_pkg::PERSON_W;

    localparam logic [WEIGHT_W-1:0] WEIGHT_MASK = WEIGHT_W'((64'd1 << WEIGHT_BITS) - 1);

    // How the loads of one table are weighted
    typedef enum int {
        W_RANDOM,
        W_SMALL,
        W_SPARSE,
        W_HEAVY
    } weight_style_t;

    // ------------------------------------------------------------------------
    // Expected picks: table, marks and totals tracked item by item
    // ------------------------------------------------------------------------
    class draw_scoreboard;
        logic [33:0]          cum_weight [MAX_PEOPLE];
        bit                   is_marked  [MAX_PEOPLE];
        int unsigned          people;
        logic [33:0]          weight_sum;
        wdr_pkg::draw_res_t   expected_picks [$];
        int unsigned          errors;

        function new();
            people     = 0;
            weight_sum = '0;
            errors     = 0;
            foreach (is_marked[i])
                is_marked[i] = 1'b0;
        endfunction

        // Work out the pick that one accepted command must produce.
        function void note_command(input wdr_pkg::draw_cmd_t c);
            wdr_pkg::draw_res_t pick;
            logic [65:0] product;
            logic [33:0] target;
            int unsigned lo;
            int unsigned hi;
            int unsigned mid;
            pick.person = '0;
            pick.status = wdr_pkg::ST_DONE;
            case (c.command)
                wdr_pkg::CMD_LOAD:
                begin
                    if (people >= MAX_PEOPLE)
                        pick.status = wdr_pkg::ST_REFUSED;
                    else
                    begin
                        weight_sum = weight_sum + {10'b0, c.weight & WEIGHT_MASK};
                        cum_weight[people] = weight_sum;
                        pick.person = PERSON_W'(people);
                        people++;
                    end
                end
                wdr_pkg::CMD_CLEAR:
                begin
                    foreach (is_marked[i])
                        is_marked[i] = 1'b0;
                    people     = 0;
                    weight_sum = '0;
                end
                default:
                begin
                    if (people == 0)
                        pick.status = wdr_pkg::ST_REFUSED;
                    else
                    begin
                        // exact floor(total * fraction / 2^32)
                        product = 66'(weight_sum) * 66'(c.random_fraction);
                        target  = product[65:32];
                        lo = 0;
                        hi = people - 1;
                        while (hi > lo)
                        begin
                            mid = lo + (hi - lo) / 2;
                            if (target < cum_weight[mid])
                                hi = mid;
                            else
                                lo = mid + 1;
                        end
                        pick.person = PERSON_W'(lo);
                        if (c.command == wdr_pkg::CMD_NEXT && is_marked[lo])
                            pick.status = wdr_pkg::ST_SEEN;
                        else
                        begin
                            is_marked[lo] = 1'b1;
                            pick.status   = wdr_pkg::ST_NEW;
                        end
                    end
                end
            endcase
            expected_picks.push_back(pick);
        endfunction

        task report_mismatch(input string what);
            $display("mismatch: %s", what);
            errors++;
        endtask

        task check_pick(input wdr_pkg::draw_res_t got);
            wdr_pkg::draw_res_t want;
            if (expected_picks.size() == 0)
            begin
                report_mismatch($sformatf("result with nothing pending: person %0d status %0d",
                                          got.person, got.status));
                return;
            end
            want = expected_picks.pop_front();
            if (got.person !== want.person)
                report_mismatch($sformatf("person %0d, expected %0d", got.person, want.person));
            if (got.status !== want.status)
                report_mismatch($sformatf("status %0d for person %0d, expected %0d",
                                          got.status, want.person, want.status));
        endtask

        task check_leftovers();
            if (expected_picks.size() != 0)
                report_mismatch($sformatf("%0d results never arrived", expected_picks.size()));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Block under test
    // ------------------------------------------------------------------------
    logic               clk;
    logic               rst_n     = 1'b0;
    logic               cmd_valid = 1'b0;
    logic               cmd_stall;
    wdr_pkg::draw_cmd_t cmd_item  = '0;
    logic               res_valid;
    logic               res_stall = 1'b0;
    wdr_pkg::draw_res_t res_item;

    weighted_draw_without_repeat_top #(
        .MAX_PEOPLE  (MAX_PEOPLE),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_item  (cmd_item),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item)
    );

    draw_scoreboard board = new();

    int unsigned items_sent   = 0;
    int unsigned tx_idle_pct  = 0;
    int unsigned rx_idle_pct  = 0;
    bit          hold_request = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Give up if the run hangs.
    initial
    begin
        #4_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Command side
    // ------------------------------------------------------------------------
    function automatic wdr_pkg::draw_cmd_t make_cmd(input wdr_pkg::command_t    command,
                                                    input logic [WEIGHT_W-1:0]   weight,
                                                    input logic [FRACTION_W-1:0] fraction);
        wdr_pkg::draw_cmd_t c;
        c.command         = command;
        c.weight          = weight;
        c.random_fraction = fraction;
        return c;
    endfunction

    function automatic logic [WEIGHT_W-1:0] pick_weight(input weight_style_t style);
        case (style)
            W_SMALL:  return WEIGHT_W'($urandom_range(255));
            W_SPARSE: return ($urandom_range(3) == 0) ? WEIGHT_W'($urandom) : '0;
            W_HEAVY:  return '1 - WEIGHT_W'($urandom_range(15));
            default:  return WEIGHT_W'($urandom);
        endcase
    endfunction

    // Favor the ends of the range; the rest is uniform.
    function automatic logic [FRACTION_W-1:0] pick_fraction();
        int unsigned roll;
        roll = $urandom_range(9);
        case (roll)
            0:       return '0;
            1:       return '1;
            2:       return FRACTION_W'($urandom_range(255));
            default: return $urandom;
        endcase
    endfunction

    // Offer one item and hold it until taken. Valid stays high between
    // back-to-back items, so only one assignment to it lands per edge.
    task automatic offer_command(input wdr_pkg::draw_cmd_t c);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_item  <= c;
        do
            @(posedge clk);
        while (cmd_stall);
        board.note_command(c);
        items_sent++;
    endtask

    // One table: clear (mostly), load a set of people, then draw from it
    // with some stray commands mixed in.
    task automatic run_table(input bit fill_up);
        int unsigned   people_n;
        int unsigned   draws_n;
        int unsigned   size_roll;
        weight_style_t style;
        size_roll = $urandom_range(99);
        if (fill_up)
            people_n = MAX_PEOPLE + $urandom_range(4, 2);   // run past capacity
        else if (size_roll < 70)
            people_n = $urandom_range(16, 1);
        else if (size_roll < 95)
            people_n = $urandom_range(100, 17);
        else
            people_n = $urandom_range(300, 101);
        style = weight_style_t'($urandom_range(3));
        if (fill_up || $urandom_range(99) < 85)
            offer_command(make_cmd(wdr_pkg::CMD_CLEAR, WEIGHT_W'($urandom), $urandom));
        for (int i = 0; i < people_n; i++)
            offer_command(make_cmd(wdr_pkg::CMD_LOAD, pick_weight(style), $urandom));
        draws_n = $urandom_range((people_n < 29) ? 2 * people_n + 2 : 60, 1);
        for (int i = 0; i < draws_n; i++)
        begin
            if ($urandom_range(99) < 8)
                offer_command(make_cmd(wdr_pkg::command_t'($urandom_range(3)),
                                       WEIGHT_W'($urandom), $urandom));
            else
                offer_command(make_cmd(($urandom_range(99) < 60) ? wdr_pkg::CMD_NEXT
                                                                 : wdr_pkg::CMD_FIRST,
                                       WEIGHT_W'($urandom), pick_fraction()));
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side: check what is taken, then pick the next stall
    // ------------------------------------------------------------------------
    initial
    begin
        int unsigned hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_valid && !res_stall)
                board.check_pick(res_item);
            if (hold_left != 0)
            begin
                res_stall <= 1'b1;
                hold_left--;
            end
            else if (hold_request)
            begin
                // hold off long enough for the block to back up its input
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES - 1;
                res_stall   <= 1'b1;
            end
            else
                res_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        tx_idle_pct = 8;
        rx_idle_pct = 78;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Refuse draws while nothing is loaded.
        offer_command(make_cmd(wdr_pkg::CMD_FIRST, WEIGHT_W'($urandom), $urandom));
        offer_command(make_cmd(wdr_pkg::CMD_NEXT, WEIGHT_W'($urandom), $urandom));
        // With only zero weights no entry rises above the target: take the last person.
        offer_command(make_cmd(wdr_pkg::CMD_LOAD, '0, $urandom));
        offer_command(make_cmd(wdr_pkg::CMD_LOAD, '0, $urandom));
        offer_command(make_cmd(wdr_pkg::CMD_FIRST, WEIGHT_W'($urandom), $urandom));
        offer_command(make_cmd(wdr_pkg::CMD_NEXT, WEIGHT_W'($urandom), '1));
        // Skip zero-weight people ahead of a heavy one; hit both fraction ends.
        offer_command(make_cmd(wdr_pkg::CMD_LOAD, '1, $urandom));
        offer_command(make_cmd(wdr_pkg::CMD_LOAD, WEIGHT_W'(1), $urandom));
        offer_command(make_cmd(wdr_pkg::CMD_FIRST, WEIGHT_W'($urandom), '0));
        offer_command(make_cmd(wdr_pkg::CMD_NEXT, WEIGHT_W'($urandom), '1));
        offer_command(make_cmd(wdr_pkg::CMD_NEXT, WEIGHT_W'($urandom), '0));
        offer_command(make_cmd(wdr_pkg::CMD_FIRST, WEIGHT_W'($urandom), 32'h8000_0000));
        // Clear drops entries and marks alike; draw again on the empty table.
        offer_command(make_cmd(wdr_pkg::CMD_CLEAR, '1, '1));
        offer_command(make_cmd(wdr_pkg::CMD_NEXT, WEIGHT_W'($urandom), $urandom));
        // Next draw reports a repeat, first draw marks regardless.
        offer_command(make_cmd(wdr_pkg::CMD_LOAD, WEIGHT_W'(1), $urandom));
        offer_command(make_cmd(wdr_pkg::CMD_LOAD, '1, $urandom));
        offer_command(make_cmd(wdr_pkg::CMD_NEXT, WEIGHT_W'($urandom), '0));
        offer_command(make_cmd(wdr_pkg::CMD_NEXT, WEIGHT_W'($urandom), '0));
        offer_command(make_cmd(wdr_pkg::CMD_FIRST, WEIGHT_W'($urandom), '0));
        offer_command(make_cmd(wdr_pkg::CMD_CLEAR, '0, '0));

        // Sender mostly busy, receiver mostly stalled.
        while (items_sent < PHASE_ITEMS)
            run_table(1'b0);

        // Swap: sender mostly idle, receiver mostly ready.
        tx_idle_pct = 78;
        rx_idle_pct = 8;
        while (items_sent < 2 * PHASE_ITEMS)
            run_table(1'b0);

        // No idling. Fill the table past capacity while the receiver holds off.
        tx_idle_pct  = 0;
        rx_idle_pct  = 0;
        hold_request = 1'b1;
        run_table(1'b1);
        while (items_sent < ITEMS_TOTAL)
            run_table(1'b0);
        cmd_valid <= 1'b0;

        // Drain, then allow for any stray output.
        while (board.expected_picks.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        board.check_leftovers();

        if (board.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
`default_nettype wire
